### rtl/htbd_pkg.sv
// ---------------------------------------------------------------------------
// htbd_pkg: shared types and helpers for the hex text byte decoder
// Command codes, character constants, decoder state and result types.
// ---------------------------------------------------------------------------
`default_nettype none

package htbd_pkg;

  typedef enum logic [1:0] {
    CMD_CHAR  = 2'd0,
    CMD_END   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_LOW_X = 8'h78;
  localparam logic [7:0] CHAR_UP_X  = 8'h58;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_F = 8'h66;

  // Token state carried from one character to the next.
  typedef struct packed {
    logic [3:0] held_nibble;
    logic       nibble_held;
    logic       zero_prefix_held;
    logic       within_token;
  } dec_state_t;

  // Outcome of one beat: whether a byte results, and its value.
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
  } dec_result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } digit_t;

  function automatic digit_t digit_value(input logic [7:0] c);
    digit_t     d;
    logic [7:0] t;
    d = '0;
    t = '0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      t = c - CHAR_0;
      d.valid = 1'b1;
      d.value = t[3:0];
    end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
      t = c - CHAR_UP_A + 8'd10;
      d.valid = 1'b1;
      d.value = t[3:0];
    end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
      t = c - CHAR_LOW_A + 8'd10;
      d.valid = 1'b1;
      d.value = t[3:0];
    end
    return d;
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
           (c == CHAR_CR) || (c == CHAR_COMMA) || (c == CHAR_SEMI);
  endfunction

endpackage

`default_nettype wire

### rtl/hex_text_byte_decoder_core.sv
// ---------------------------------------------------------------------------
// hex_text_byte_decoder_core: hex text to byte decoder
// Turns a stream of text characters into bytes, pairing hex digits.
// ---------------------------------------------------------------------------
// Usage: each input beat carries cmd and char_code; cmd selects a text
// character, an end-of-text flush, a clear of pending state or no action. Each
// input beat gives zero or one output beat carrying data_byte.
// Path: an accepted beat sits in the input register and is decoded there;
// a resulting byte is loaded into the result register when the beat leaves
// the input register, and is shown on out_valid from then on.
// Throughput: one character per cycle while in_stall is low, set by the single
// decode step between the input register and the result register.
// Reset: rst clears the token state and both valid flags; no beats are held.
// Stall: while out_stall holds a byte, characters that give no byte keep
// flowing; a character that would give a byte waits in the input register,
// and then in_stall rises until the receiver takes the held byte.
// ---------------------------------------------------------------------------
`default_nettype none

module hex_text_byte_decoder_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] char_code,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      data_byte
);
  import htbd_pkg::*;

  logic        in_full;
  cmd_t        in_cmd;
  logic [7:0]  in_char;
  logic        advance;
  logic        out_free;
  dec_result_t res;

  // A beat leaves the input register when its byte has room, or it has none.
  assign advance  = in_full && (out_free || !res.emit);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_cmd  <= cmd_t'(cmd);
      in_char <= char_code;
    end
  end

  htbd_step u_step (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .cmd       (in_cmd),
    .char_code (in_char),
    .res       (res)
  );

  htbd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_byte (data_byte)
  );

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full)
    else $error("input stalled while its register is empty");

  a_held_beat_waits: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> in_full)
    else $error("stalled input beat lost");

  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && res.emit))
    else $error("input stalled without a blocked byte");

endmodule

`default_nettype wire

### rtl/htbd_step.sv
// ---------------------------------------------------------------------------
// htbd_step: per-character decode step and token state
// Decides the result of one beat from the token state and updates that state.
// ---------------------------------------------------------------------------
`default_nettype none

module htbd_step (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire htbd_pkg::cmd_t       cmd,
  input  wire logic [7:0]           char_code,
  output htbd_pkg::dec_result_t     res
);
  import htbd_pkg::*;

  dec_state_t  state;
  dec_state_t  state_next;
  dec_state_t  cur;
  dec_result_t end_res;
  digit_t      dig;
  logic        is_x;

  assign dig  = digit_value(char_code);
  assign is_x = (char_code == CHAR_LOW_X) || (char_code == CHAR_UP_X);

  // A byte that ending the token would give: a held '0' reads as nibble zero.
  assign end_res.emit = state.zero_prefix_held || state.nibble_held;
  assign end_res.data = {4'd0, state.zero_prefix_held ? 4'd0 : state.held_nibble};

  always_comb begin
    state_next = state;
    res        = '0;
    cur        = state;
    case (cmd)
      CMD_END: begin
        res        = end_res;
        state_next = '0;
      end
      CMD_CLEAR: begin
        state_next = '0;
      end
      CMD_CHAR: begin
        if (is_separator(char_code)) begin
          res        = end_res;
          state_next = '0;
        end else if (state.zero_prefix_held && is_x) begin
          state_next.zero_prefix_held = 1'b0;
          state_next.within_token     = 1'b1;
        end else begin
          // A held '0' not followed by x becomes the pending nibble.
          if (state.zero_prefix_held) begin
            cur.zero_prefix_held = 1'b0;
            cur.nibble_held      = 1'b1;
            cur.held_nibble      = 4'd0;
          end
          if (!dig.valid) begin
            res        = end_res;
            state_next = '0;
          end else if (!cur.within_token && dig.value == 4'd0 && !cur.nibble_held) begin
            state_next                  = cur;
            state_next.zero_prefix_held = 1'b1;
            state_next.within_token     = 1'b1;
          end else if (!cur.nibble_held) begin
            state_next              = cur;
            state_next.within_token = 1'b1;
            state_next.held_nibble  = dig.value;
            state_next.nibble_held  = 1'b1;
          end else begin
            res.emit                = 1'b1;
            res.data                = {cur.held_nibble, dig.value};
            state_next              = cur;
            state_next.within_token = 1'b1;
            state_next.nibble_held  = 1'b0;
            state_next.held_nibble  = 4'd0;
          end
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  a_no_double_pending: assert property (@(posedge clk) disable iff (rst)
    !(state.zero_prefix_held && state.nibble_held))
    else $error("held zero and pending nibble at the same time");

  a_zero_in_token: assert property (@(posedge clk) disable iff (rst)
    state.zero_prefix_held |-> state.within_token)
    else $error("held zero outside a token");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (fire && cmd == CMD_CLEAR) |=> (state == '0))
    else $error("clear left token state behind");

  a_end_empties: assert property (@(posedge clk) disable iff (rst)
    (fire && cmd == CMD_END) |=> (state == '0))
    else $error("end left token state behind");

endmodule

`default_nettype wire

### rtl/htbd_out_reg.sv
// ---------------------------------------------------------------------------
// htbd_out_reg: result register for decoded bytes
// Holds one decoded byte until the receiver takes the beat.
// ---------------------------------------------------------------------------
`default_nettype none

module htbd_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire htbd_pkg::dec_result_t res,
  output logic                      free,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                data_byte
);
  import htbd_pkg::*;

  // The register can take a new byte when empty or emptying this cycle.
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res.emit || (out_valid && out_stall);
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.emit) begin
      data_byte <= res.data;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(load && res.emit))
    else $error("stalled byte overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (load && res.emit) |=> out_valid)
    else $error("loaded byte not shown");

  a_empty_stays: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !(load && res.emit)) |=> !out_valid)
    else $error("byte appeared without a load");

endmodule

`default_nettype wire
